FILE: rtl/dcrp_pkg.sv
package dcrp_pkg;

   localparam int unsigned ADDR_W = 32;
   localparam int unsigned TICK_W = 16;
   localparam int unsigned POS_W  = 10;

   // command codes
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_BYTE  = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   // configuration register indexes
   localparam logic CSR_TRANSACTION_ID = 1'b0;
   localparam logic CSR_TIMEOUT_TICKS  = 1'b1;

   localparam logic [31:0] TRANSACTION_ID_RESET = 32'hDEAD_BEEF;
   localparam logic [15:0] TIMEOUT_TICKS_RESET  = 16'd90;

   localparam logic [POS_W-1:0] REPLY_MIN_LEN = 10'd552;
   localparam logic [POS_W-1:0] OPT_START     = 10'd240;
   localparam logic [POS_W-1:0] OPT_SPACE     = 10'd312;
   localparam logic [7:0]       OPT_MSG_TYPE  = 8'd53;
   localparam logic [7:0]       OPT_END       = 8'd255;
   localparam logic [7:0]       OPT_PAD       = 8'd0;
   localparam logic [7:0]       OP_REPLY      = 8'd2;
   localparam logic [7:0]       TYPE_OFFER    = 8'd2;
   localparam logic [7:0]       TYPE_ACK      = 8'd5;

   typedef enum logic [2:0] {
      EV_DISCOVER = 3'd0,
      EV_REQUEST  = 3'd1,
      EV_ASSIGNED = 3'd2,
      EV_DONE     = 3'd3,
      EV_NO_OFFER = 3'd4,
      EV_NO_ACK   = 3'd5
   } event_type;

   typedef enum logic [1:0] {
      PH_IDLE       = 2'd0,
      PH_WAIT_OFFER = 2'd1,
      PH_WAIT_ACK   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      WK_CODE = 2'd0,
      WK_LEN  = 2'd1,
      WK_DATA = 2'd2,
      WK_STOP = 2'd3
   } walk_type;

   // one queue entry: first result, plus a flag for a trailing done
   typedef struct packed {
      event_type         ev;
      logic [ADDR_W-1:0] address;
      logic              with_done;
   } entry_type;

endpackage

FILE: rtl/dcrp_front.sv
module dcrp_front
   import dcrp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data,
   input  logic        q_full,
   output logic        q_push,
   output entry_type   q_entry
);

   logic [31:0]       tid_ff, tid_in;
   logic [TICK_W-1:0] timeout_ff, timeout_in;
   phase_type         phase_ff, phase_in;
   logic              ack_seen_ff, ack_seen_in;
   logic [ADDR_W-1:0] offered_addr_ff, offered_addr_in;
   logic [TICK_W-1:0] tick_count_ff, tick_count_in;
   logic [POS_W-1:0]  byte_pos_ff, byte_pos_in;
   logic              header_ok_ff, header_ok_in;
   logic [ADDR_W-1:0] reply_addr_ff, reply_addr_in;
   walk_type          walk_mode_ff, walk_mode_in;
   logic [7:0]        skip_left_ff, skip_left_in;
   logic [7:0]        option_code_ff, option_code_in;
   logic [7:0]        msg_kind_ff, msg_kind_in;

   // reply fields after this byte, before any end-of-datagram clear
   logic [POS_W-1:0]  p_pos;
   logic              p_hdr;
   logic [ADDR_W-1:0] p_addr;
   walk_type          p_walk;
   logic [7:0]        p_skip;
   logic [7:0]        p_code;
   logic [7:0]        p_type;

   logic [POS_W-1:0]  opt_idx;
   logic [POS_W-1:0]  len_sum;
   logic [7:0]        tid_byte;
   logic [TICK_W-1:0] tick_inc;
   logic              accept;
   logic              reply_ok;
   logic              offer_hit;
   logic              ack_hit;
   logic              tick_expire;
   logic              waiting;

   assign req_ready = !q_full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   assign opt_idx  = byte_pos_ff - OPT_START;
   assign len_sum  = opt_idx + 10'd1 + {2'b00, req_data_byte};
   assign tick_inc = tick_count_ff + 16'd1;
   assign waiting  = (phase_ff == PH_WAIT_OFFER) || (phase_ff == PH_WAIT_ACK);

   always_comb begin
      case (byte_pos_ff[1:0])
         2'd0:    tid_byte = tid_ff[31:24];
         2'd1:    tid_byte = tid_ff[23:16];
         2'd2:    tid_byte = tid_ff[15:8];
         default: tid_byte = tid_ff[7:0];
      endcase
   end

   // byte parser and option walk
   always_comb begin
      p_pos  = byte_pos_ff;
      p_hdr  = header_ok_ff;
      p_addr = reply_addr_ff;
      p_walk = walk_mode_ff;
      p_skip = skip_left_ff;
      p_code = option_code_ff;
      p_type = msg_kind_ff;
      if (byte_pos_ff < REPLY_MIN_LEN) begin
         if (byte_pos_ff == 10'd0 && req_data_byte != OP_REPLY) begin
            p_hdr = 1'b0;
         end
         if (byte_pos_ff >= 10'd4 && byte_pos_ff <= 10'd7 && tid_byte != req_data_byte) begin
            p_hdr = 1'b0;
         end
         if (byte_pos_ff >= 10'd16 && byte_pos_ff <= 10'd19) begin
            p_addr = {reply_addr_ff[23:0], req_data_byte};
         end
         if (byte_pos_ff >= OPT_START) begin
            unique case (walk_mode_ff)
               WK_CODE: begin
                  if (req_data_byte == OPT_END) begin
                     p_walk = WK_STOP;
                  end else if (req_data_byte != OPT_PAD) begin
                     p_code = req_data_byte;
                     p_walk = WK_LEN;
                  end
               end
               WK_LEN: begin
                  if (len_sum > OPT_SPACE) begin
                     p_walk = WK_STOP;
                  end else if (req_data_byte == 8'd0) begin
                     p_walk = WK_CODE;
                  end else begin
                     // only a one-byte message type option is tracked
                     p_code = (option_code_ff == OPT_MSG_TYPE && req_data_byte == 8'd1)
                              ? OPT_MSG_TYPE : 8'd0;
                     p_skip = req_data_byte;
                     p_walk = WK_DATA;
                  end
               end
               WK_DATA: begin
                  if (option_code_ff == OPT_MSG_TYPE) begin
                     p_type = req_data_byte;
                  end
                  p_skip = skip_left_ff - 8'd1;
                  if (skip_left_ff == 8'd1) begin
                     p_walk = WK_CODE;
                  end
               end
               default: begin
               end
            endcase
         end
         p_pos = byte_pos_ff + 10'd1;
      end
   end

   assign reply_ok    = (p_pos >= REPLY_MIN_LEN) && p_hdr;
   assign offer_hit   = accept && req_command == CMD_BYTE && req_last_byte && reply_ok
                        && p_type == TYPE_OFFER;
   assign ack_hit     = accept && req_command == CMD_BYTE && req_last_byte && reply_ok
                        && p_type == TYPE_ACK;
   assign tick_expire = accept && req_command == CMD_TICK && waiting
                        && (tick_inc >= timeout_ff || tick_inc == 16'd0);

   // exchange phase, next state
   always_comb begin
      phase_in = phase_ff;
      if (accept && req_command == CMD_START) begin
         phase_in = PH_WAIT_OFFER;
      end else if (offer_hit && phase_ff == PH_WAIT_OFFER) begin
         phase_in = ack_seen_ff ? PH_IDLE : PH_WAIT_ACK;
      end else if (ack_hit && phase_ff == PH_WAIT_ACK) begin
         phase_in = PH_IDLE;
      end else if (tick_expire) begin
         phase_in = PH_IDLE;
      end
   end

   // exchange phase, outputs into the queue
   always_comb begin
      q_push            = 1'b0;
      q_entry.ev        = EV_DISCOVER;
      q_entry.address   = '0;
      q_entry.with_done = 1'b0;
      if (accept && req_command == CMD_START) begin
         q_push = 1'b1;
      end else if (offer_hit && phase_ff == PH_WAIT_OFFER) begin
         q_push            = 1'b1;
         q_entry.ev        = EV_REQUEST;
         q_entry.address   = p_addr;
         q_entry.with_done = ack_seen_ff;
      end else if (ack_hit) begin
         q_push            = 1'b1;
         q_entry.ev        = EV_ASSIGNED;
         q_entry.address   = p_addr;
         q_entry.with_done = (phase_ff == PH_WAIT_ACK);
      end else if (tick_expire) begin
         q_push     = 1'b1;
         q_entry.ev = (phase_ff == PH_WAIT_OFFER) ? EV_NO_OFFER : EV_NO_ACK;
      end
   end

   always_comb begin
      tid_in          = tid_ff;
      timeout_in      = timeout_ff;
      ack_seen_in     = ack_seen_ff;
      offered_addr_in = offered_addr_ff;
      tick_count_in   = tick_count_ff;
      byte_pos_in     = byte_pos_ff;
      header_ok_in    = header_ok_ff;
      reply_addr_in   = reply_addr_ff;
      walk_mode_in    = walk_mode_ff;
      skip_left_in    = skip_left_ff;
      option_code_in  = option_code_ff;
      msg_kind_in     = msg_kind_ff;

      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_TRANSACTION_ID) begin
            tid_in = csr_data;
         end else begin
            timeout_in = csr_data[TICK_W-1:0];
         end
      end

      if (accept) begin
         case (req_command)
            CMD_START: begin
               ack_seen_in   = 1'b0;
               tick_count_in = '0;
            end
            CMD_BYTE: begin
               if (req_last_byte) begin
                  byte_pos_in    = '0;
                  header_ok_in   = 1'b1;
                  reply_addr_in  = '0;
                  walk_mode_in   = WK_CODE;
                  skip_left_in   = '0;
                  option_code_in = '0;
                  msg_kind_in    = '0;
               end else begin
                  byte_pos_in    = p_pos;
                  header_ok_in   = p_hdr;
                  reply_addr_in  = p_addr;
                  walk_mode_in   = p_walk;
                  skip_left_in   = p_skip;
                  option_code_in = p_code;
                  msg_kind_in    = p_type;
               end
               if (offer_hit) begin
                  offered_addr_in = p_addr;
                  if (phase_ff == PH_WAIT_OFFER) begin
                     tick_count_in = '0;
                  end
               end
               if (ack_hit) begin
                  ack_seen_in = 1'b1;
               end
            end
            CMD_TICK: begin
               if (waiting) begin
                  tick_count_in = tick_inc;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tid_ff          <= TRANSACTION_ID_RESET;
         timeout_ff      <= TIMEOUT_TICKS_RESET;
         phase_ff        <= PH_IDLE;
         ack_seen_ff     <= 1'b0;
         offered_addr_ff <= '0;
         tick_count_ff   <= '0;
         byte_pos_ff     <= '0;
         header_ok_ff    <= 1'b1;
         reply_addr_ff   <= '0;
         walk_mode_ff    <= WK_CODE;
         skip_left_ff    <= '0;
         option_code_ff  <= '0;
         msg_kind_ff     <= '0;
      end else begin
         tid_ff          <= tid_in;
         timeout_ff      <= timeout_in;
         phase_ff        <= phase_in;
         ack_seen_ff     <= ack_seen_in;
         offered_addr_ff <= offered_addr_in;
         tick_count_ff   <= tick_count_in;
         byte_pos_ff     <= byte_pos_in;
         header_ok_ff    <= header_ok_in;
         reply_addr_ff   <= reply_addr_in;
         walk_mode_ff    <= walk_mode_in;
         skip_left_ff    <= skip_left_in;
         option_code_ff  <= option_code_in;
         msg_kind_ff     <= msg_kind_in;
      end
   end

endmodule

FILE: rtl/dcrp_queue.sv
module dcrp_queue
   import dcrp_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      empty,
   output entry_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/dcrp_back.sv
module dcrp_back
   import dcrp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  entry_type         q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_event_res,
   output logic [ADDR_W-1:0] rsp_address,
   output logic              rsp_last
);

   logic              valid_ff, valid_in;
   event_type         event_ff, event_in;
   logic [ADDR_W-1:0] address_ff, address_in;
   logic              last_ff, last_in;
   logic              done_pending_ff, done_pending_in;
   logic              out_free;

   assign out_free = !valid_ff || rsp_ready;
   assign q_pop    = out_free && !done_pending_ff && !q_empty;

   always_comb begin
      valid_in        = valid_ff;
      event_in        = event_ff;
      address_in      = address_ff;
      last_in         = last_ff;
      done_pending_in = done_pending_ff;
      if (out_free) begin
         if (done_pending_ff) begin
            // trailing done of a two-result item
            valid_in        = 1'b1;
            event_in        = EV_DONE;
            address_in      = '0;
            last_in         = 1'b1;
            done_pending_in = 1'b0;
         end else if (!q_empty) begin
            valid_in        = 1'b1;
            event_in        = q_head.ev;
            address_in      = q_head.address;
            last_in         = !q_head.with_done;
            done_pending_in = q_head.with_done;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         done_pending_ff <= 1'b0;
      end else begin
         valid_ff        <= valid_in;
         done_pending_ff <= done_pending_in;
      end
      event_ff   <= event_in;
      address_ff <= address_in;
      last_ff    <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_event_res = event_ff;
   assign rsp_address   = address_ff;
   assign rsp_last      = last_ff;

endmodule

FILE: rtl/dhcp_client_reply_parser.sv
// DHCP client exchange with a byte-serial reply parser.
// req_ channel: one command per transfer (start, reply byte, timer tick);
// reply bytes may stream one per cycle with req_last_byte on the final byte.
// rsp_ channel: zero, one or two events per command; rsp_last marks the
// final event of a command. csr_ channel: index 0 transaction id, index 1
// timeout in ticks; always ready, write only while no command is in flight.
// The front end parses and updates the exchange state in the cycle the
// command is taken, and queues its events; the back end presents them from
// an output register one per cycle while rsp_ready is high. Throughput is
// one command per cycle, bounded by the output rate of one event per cycle
// when commands produce two events. When the receiver stalls, events
// collect in the QUEUE_DEPTH entry queue and req_ready falls once it is
// full. Reset is synchronous: the exchange goes idle, the parser clears
// and the registers take their reset values.
module dhcp_client_reply_parser
   import dcrp_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_command,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_event_res,
   output logic [ADDR_W-1:0] rsp_address,
   output logic              rsp_last,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [31:0]       csr_data
);

   logic      q_full;
   logic      q_push;
   logic      q_pop;
   logic      q_empty;
   entry_type q_entry;
   entry_type q_head;

   dcrp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (q_entry)
   );

   dcrp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   dcrp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_event_res (rsp_event_res),
      .rsp_address   (rsp_address),
      .rsp_last      (rsp_last)
   );

endmodule

FILE: tb/dhcp_client_reply_parser_tb.sv
`timescale 1ns / 1ps

module dhcp_client_reply_parser_tb;
   import dcrp_pkg::*;

   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         FRAME_MAX   = 560;

   typedef struct {
      event_type   ev;
      logic [31:0] addr;
      logic        last;
   } dhcp_event_type;

   // tracks the client exchange and the reply parser, and holds the events still owed
   class dhcp_tracker_type;
      logic [31:0] txid;
      logic [15:0] tick_limit;
      phase_type   phase;
      logic        ack_seen;
      logic [31:0] offered;
      logic [15:0] ticks;
      int unsigned pos;
      logic        hdr_ok;
      logic [31:0] yiaddr;
      walk_type    walk;
      logic [7:0]  skip_left;
      logic [7:0]  opt_code;
      logic [7:0]  msg_kind;
      dhcp_event_type owed[$];
      int          mismatches;

      function new();
         txid       = TRANSACTION_ID_RESET;
         tick_limit = TIMEOUT_TICKS_RESET;
         phase      = PH_IDLE;
         ack_seen   = 1'b0;
         offered    = '0;
         ticks      = '0;
         mismatches = 0;
         clear_reply();
      endfunction

      function void clear_reply();
         pos       = 0;
         hdr_ok    = 1'b1;
         yiaddr    = '0;
         walk      = WK_CODE;
         skip_left = '0;
         opt_code  = '0;
         msg_kind  = '0;
      endfunction

      function void set_register(logic idx, logic [31:0] val);
         if (idx == CSR_TRANSACTION_ID) txid = val;
         else tick_limit = val[15:0];
      endfunction

      function void owe_event(event_type ev, logic [31:0] addr);
         owed.push_back('{ev: ev, addr: addr, last: 1'b0});
      endfunction

      function void walk_option(int unsigned idx, logic [7:0] b);
         case (walk)
            WK_CODE: begin
               if (b == OPT_END) walk = WK_STOP;
               else if (b != OPT_PAD) begin
                  opt_code = b;
                  walk = WK_LEN;
               end
            end
            WK_LEN: begin
               // option data running past the options area ends the walk
               if (idx + 1 + b > OPT_SPACE) walk = WK_STOP;
               else if (b == 8'd0) walk = WK_CODE;
               else begin
                  opt_code  = (opt_code == OPT_MSG_TYPE && b == 8'd1) ? OPT_MSG_TYPE : 8'd0;
                  skip_left = b;
                  walk      = WK_DATA;
               end
            end
            WK_DATA: begin
               if (opt_code == OPT_MSG_TYPE) msg_kind = b;
               skip_left = skip_left - 8'd1;
               if (skip_left == 8'd0) walk = WK_CODE;
            end
            default: ;
         endcase
      endfunction

      function void take_byte(logic [7:0] b);
         if (pos >= REPLY_MIN_LEN) return;
         if (pos == 0 && b != OP_REPLY) hdr_ok = 1'b0;
         if (pos >= 4 && pos <= 7 && 8'(txid >> ((7 - pos) * 8)) != b) hdr_ok = 1'b0;
         if (pos >= 16 && pos <= 19) yiaddr = {yiaddr[23:0], b};
         if (pos >= OPT_START) walk_option(pos - OPT_START, b);
         pos++;
      endfunction

      function void note_command(logic [1:0] cmd, logic [7:0] b, logic lb);
         int          n0;
         logic        ok;
         logic [7:0]  mt;
         logic [31:0] ya;
         n0 = owed.size();
         case (cmd)
            CMD_START: begin
               ack_seen = 1'b0;
               ticks    = '0;
               phase    = PH_WAIT_OFFER;
               owe_event(EV_DISCOVER, '0);
            end
            CMD_BYTE: begin
               take_byte(b);
               if (lb) begin
                  ok = (pos >= REPLY_MIN_LEN) && hdr_ok;
                  mt = msg_kind;
                  ya = yiaddr;
                  clear_reply();
                  if (ok && mt == TYPE_OFFER) begin
                     offered = ya;
                     if (phase == PH_WAIT_OFFER) begin
                        owe_event(EV_REQUEST, offered);
                        ticks = '0;
                        if (ack_seen) begin
                           owe_event(EV_DONE, '0);
                           phase = PH_IDLE;
                        end else begin
                           phase = PH_WAIT_ACK;
                        end
                     end
                  end else if (ok && mt == TYPE_ACK) begin
                     ack_seen = 1'b1;
                     owe_event(EV_ASSIGNED, ya);
                     if (phase == PH_WAIT_ACK) begin
                        owe_event(EV_DONE, '0);
                        phase = PH_IDLE;
                     end
                  end
               end
            end
            CMD_TICK: begin
               if (phase != PH_IDLE) begin
                  ticks = ticks + 16'd1;
                  // a zero limit behaves as a limit of one
                  if (ticks >= tick_limit || ticks == 16'd0) begin
                     if (phase == PH_WAIT_OFFER) owe_event(EV_NO_OFFER, '0);
                     else owe_event(EV_NO_ACK, '0);
                     phase = PH_IDLE;
                  end
               end
            end
            default: ;
         endcase
         if (owed.size() > n0) owed[owed.size() - 1].last = 1'b1;
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%s", msg);
      endfunction

      function void check_event(logic [2:0] ev, logic [31:0] addr, logic lst);
         dhcp_event_type want;
         if (owed.size() == 0) begin
            report($sformatf("unexpected event: event %0d address %h last %0b", ev, addr, lst));
            return;
         end
         want = owed.pop_front();
         if (ev !== want.ev || addr !== want.addr || lst !== want.last)
            report($sformatf("event mismatch: expected %0d/%h/%0b, got %0d/%h/%0b",
                             want.ev, want.addr, want.last, ev, addr, lst));
      endfunction
   endclass

   logic              clock         = 1'b0;
   logic              reset         = 1'b1;
   logic              req_valid     = 1'b0;
   logic              req_ready;
   logic [1:0]        req_command   = CMD_START;
   logic [7:0]        req_data_byte = '0;
   logic              req_last_byte = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready     = 1'b0;
   logic [2:0]        rsp_event_res;
   logic [ADDR_W-1:0] rsp_address;
   logic              rsp_last;
   logic              csr_valid     = 1'b0;
   logic              csr_ready;
   logic              csr_index     = CSR_TRANSACTION_ID;
   logic [31:0]       csr_data      = '0;

   dhcp_tracker_type     tracker;
   int                   sent_items    = 0;
   int                   burst_left    = 0;
   int                   cycle_count   = 0;
   int                   squeeze_count = 0;
   logic [7:0]           frame [0:FRAME_MAX-1];
   int                   opt_fill;

   dhcp_client_reply_parser dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_event_res (rsp_event_res),
      .rsp_address   (rsp_address),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) tracker.note_command(req_command, req_data_byte, req_last_byte);
         if (rsp_valid && rsp_ready) tracker.check_event(rsp_event_res, rsp_address, rsp_last);
      end
   end

   // receiver: shifting stall patterns, plus a long hold-off when asked for one
   int rx_cycles    = 0;
   int hold_left    = 0;
   int squeeze_seen = 0;
   int pattern      = 0;
   int pattern_left = 0;

   always @(posedge clock) begin
      rx_cycles++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (squeeze_seen != squeeze_count) begin
         squeeze_seen = squeeze_count;
         hold_left    = 250;
         rsp_ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            pattern      = $urandom_range(0, 3);
            pattern_left = $urandom_range(16, 96);
         end
         pattern_left--;
         case (pattern)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom);
            2:       rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (rx_cycles % 3 == 0);
         endcase
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILED: results differ");
      $finish;
   end

   // sender works in bursts; valid is only dropped at the start of a gap
   task automatic send_item(logic [1:0] cmd, logic [7:0] b, logic lb);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_data_byte <= b;
      req_last_byte <= lb;
      sent_items++;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_register(logic idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tracker.set_register(idx, val);
      @(posedge clock);
   endtask

   // wait for every owed event, then let a command with no event finish
   task automatic settle();
      req_valid <= 1'b0;
      // the last transfer is noted by the monitor at the edge just passed
      @(posedge clock);
      while (tracker.owed.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   function void put_opt_byte(logic [7:0] v);
      if (opt_fill < OPT_SPACE) frame[OPT_START + opt_fill] = v;
      opt_fill++;
   endfunction

   function void put_option(logic [7:0] code, int len, logic [7:0] first);
      put_opt_byte(code);
      put_opt_byte(8'(len));
      for (int i = 0; i < len; i++) put_opt_byte((i == 0) ? first : 8'($urandom));
   endfunction

   function void put_filler();
      logic [7:0] code;
      code = 8'($urandom_range(1, 254));
      if (code == OPT_MSG_TYPE) code = code + 8'd1;
      if ($urandom_range(0, 3) == 0) put_opt_byte(OPT_PAD);
      else put_option(code, $urandom_range(0, 6), 8'($urandom));
   endfunction

   task automatic send_reply(logic [7:0] mt);
      int  len, lsel, bsel, esel, n, k;
      bit  placed;
      for (k = 0; k < FRAME_MAX; k++) frame[k] = 8'($urandom);
      frame[0] = OP_REPLY;
      for (k = 0; k < 4; k++) frame[4 + k] = 8'(tracker.txid >> (24 - 8 * k));
      opt_fill = 0;
      repeat ($urandom_range(0, 3)) put_filler();
      // message type of the wrong length is not taken
      if ($urandom_range(0, 9) == 0) put_option(OPT_MSG_TYPE, 2, 8'($urandom));
      // an earlier message type that the later one overrides
      if ($urandom_range(0, 6) == 0) put_option(OPT_MSG_TYPE, 1, 8'($urandom));
      placed = ($urandom_range(0, 7) != 0);
      if (placed) put_option(OPT_MSG_TYPE, 1, mt);
      repeat ($urandom_range(0, 3)) put_filler();
      esel = $urandom_range(0, 9);
      if (esel < 7) begin
         put_opt_byte(OPT_END);
      end else if (esel == 7) begin
         // options fill the area right to its end
         while (OPT_SPACE - opt_fill >= 2) begin
            n = $urandom_range(0, 60);
            if (n > OPT_SPACE - 2 - opt_fill) n = OPT_SPACE - 2 - opt_fill;
            put_option(8'($urandom_range(1, 254)), n, 8'($urandom));
         end
      end else if (esel == 8) begin
         // last option claims more data than the area holds
         while (OPT_SPACE - opt_fill > 40)
            put_option(8'($urandom_range(1, 254)), $urandom_range(0, 30), 8'($urandom));
         put_option(8'($urandom_range(1, 254)), OPT_SPACE - 1 - opt_fill + $urandom_range(0, 2),
                    8'($urandom));
      end
      lsel = $urandom_range(0, 19);
      if (lsel == 0) len = $urandom_range(1, 40);
      else if (lsel == 1) len = $urandom_range(OPT_START + 1, REPLY_MIN_LEN - 1);
      else len = REPLY_MIN_LEN + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0);
      bsel = $urandom_range(0, 19);
      if (bsel == 0) frame[0] = frame[0] ^ 8'($urandom_range(1, 255));
      else if (bsel == 1) begin
         k = 4 + $urandom_range(0, 3);
         frame[k] = frame[k] ^ 8'($urandom_range(1, 255));
      end
      for (k = 0; k < len; k++) begin
         // now and then a start or tick lands in the middle of a reply
         if ($urandom_range(0, 399) == 0)
            send_item($urandom_range(0, 1) ? CMD_START : CMD_TICK, 8'($urandom), 1'($urandom));
         send_item(CMD_BYTE, frame[k], k == len - 1);
      end
   endtask

   // short commands up to the item budget, plus the given number of reply pairs
   task automatic run_traffic(int budget, int pairs);
      int  base, sel, n;
      logic [7:0] mt;
      base = sent_items;
      // receiver holds off while starts pile up, so the input must stall
      squeeze_count <= squeeze_count + 1;
      repeat (12) send_item(CMD_START, 8'($urandom), 1'($urandom));
      while (sent_items - base < budget || pairs > 0) begin
         sel = $urandom_range(0, (pairs > 0) ? 49 : 39);
         if (sel < 12) begin
            send_item(CMD_START, 8'($urandom), 1'($urandom));
         end else if (sel < 26) begin
            if (tracker.tick_limit != 0 && tracker.tick_limit <= 8)
               n = $urandom_range(1, tracker.tick_limit + 1);
            else
               n = $urandom_range(1, 6);
            repeat (n) send_item(CMD_TICK, 8'($urandom), 1'($urandom));
         end else if (sel < 40) begin
            repeat ($urandom_range(1, 8))
               send_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
         end else begin
            pairs--;
            // close off any partial reply so the pair starts at byte zero
            send_item(CMD_BYTE, 8'($urandom), 1'b1);
            if ($urandom_range(0, 4) != 0) send_item(CMD_START, 8'($urandom), 1'($urandom));
            send_reply(($urandom_range(0, 3) != 0) ? TYPE_OFFER : TYPE_ACK);
            repeat ($urandom_range(0, 2)) send_item(CMD_TICK, 8'($urandom), 1'($urandom));
            if ($urandom_range(0, 4) == 0) mt = 8'($urandom);
            else mt = ($urandom_range(0, 3) != 0) ? TYPE_ACK : TYPE_OFFER;
            send_reply(mt);
         end
      end
      settle();
   endtask

   initial begin
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: idle tick, unused command, short replies, restart
      send_item(CMD_TICK, 8'hFF, 1'b1);
      send_item(CMD_UNUSED, 8'hFF, 1'b1);
      send_item(CMD_BYTE, 8'h00, 1'b0);
      send_item(CMD_BYTE, 8'hFF, 1'b1);
      send_item(CMD_START, 8'h00, 1'b0);
      send_item(CMD_START, 8'hFF, 1'b1);
      send_item(CMD_TICK, 8'h00, 1'b0);
      send_item(CMD_BYTE, OP_REPLY, 1'b1);
      settle();

      write_register(CSR_TRANSACTION_ID, 32'h0000_0000);
      write_register(CSR_TIMEOUT_TICKS, 32'd1);
      send_item(CMD_TICK, 8'h00, 1'b0);
      send_item(CMD_START, 8'h00, 1'b0);
      send_item(CMD_TICK, 8'hFF, 1'b1);
      send_item(CMD_TICK, 8'h00, 1'b0);
      send_item(CMD_START, 8'h00, 1'b0);
      send_item(CMD_BYTE, 8'hFF, 1'b0);
      // restart while a reply is half received
      send_item(CMD_START, 8'hFF, 1'b0);
      send_item(CMD_TICK, 8'h00, 1'b1);
      send_item(CMD_BYTE, 8'h00, 1'b1);
      settle();
      run_traffic(150, 0);

      write_register(CSR_TRANSACTION_ID, 32'hFFFF_FFFF);
      write_register(CSR_TIMEOUT_TICKS, 32'd65535);
      run_traffic(150, 1);

      write_register(CSR_TRANSACTION_ID, 32'($urandom));
      write_register(CSR_TIMEOUT_TICKS, 32'd0);
      run_traffic(100, 0);

      write_register(CSR_TRANSACTION_ID, 32'($urandom));
      write_register(CSR_TIMEOUT_TICKS, 32'($urandom_range(2, 6)));
      run_traffic(120, 0);

      settle();
      if (tracker.mismatches == 0 && tracker.owed.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
